// ----- sv/owm_pkg.sv -----
// shared types, constants and codes for the one-wire bus master
`default_nettype none
package owm_pkg;

  localparam int unsigned TIME_BITS = 12;
  localparam int unsigned TMAX = (1 << TIME_BITS) - 1;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // register indexes (word address bits)
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [2:0] REG_SLOT_GAP      = 3'd3;
  localparam logic [2:0] REG_SHORT_LOW     = 3'd4;
  localparam logic [2:0] REG_ONE_RELEASE   = 3'd5;
  localparam logic [2:0] REG_ZERO_LOW      = 3'd6;
  localparam logic [2:0] REG_READ_TAIL     = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RLOW   = 4'd1,
    PH_RWAIT  = 4'd2,
    PH_RWATCH = 4'd3,
    PH_RTAIL  = 4'd4,
    PH_GAP    = 4'd5,
    PH_SLOW   = 4'd6,
    PH_REL    = 4'd7,
    PH_SAMPLE = 4'd8,
    PH_RDTAIL = 4'd9
  } phase_t;

  typedef struct packed {
    logic [11:0] reset_low_time;
    logic [11:0] presence_wait_time;
    logic [11:0] reset_tail_time;
    logic [7:0]  slot_gap_time;
    logic [7:0]  short_low_time;
    logic [7:0]  one_release_time;
    logic [7:0]  zero_low_time;
    logic [7:0]  read_tail_time;
  } cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [TIME_BITS-1:0] time_left;
    logic [2:0]           bit_index;
    logic [7:0]           shift_data;
    logic                 is_read;
    logic [7:0]           last_rx;
  } mst_state_t;

  typedef struct packed {
    logic drive_low;
    logic busy;
    logic done;
  } tick_res_t;

endpackage
`default_nettype wire

// ----- sv/owm_regs.sv -----
// apb timing register file
`default_nettype none
module owm_regs
  import owm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_time     <= 12'd490;
      cfg.presence_wait_time <= 12'd60;
      cfg.reset_tail_time    <= 12'd410;
      cfg.slot_gap_time      <= 8'd1;
      cfg.short_low_time     <= 8'd5;
      cfg.one_release_time   <= 8'd55;
      cfg.zero_low_time      <= 8'd60;
      cfg.read_tail_time     <= 8'd60;
    end else if (wr_en) begin
      case (idx)
        REG_RESET_LOW:     cfg.reset_low_time     <= pwdata[11:0];
        REG_PRESENCE_WAIT: cfg.presence_wait_time <= pwdata[11:0];
        REG_RESET_TAIL:    cfg.reset_tail_time    <= pwdata[11:0];
        REG_SLOT_GAP:      cfg.slot_gap_time      <= pwdata[7:0];
        REG_SHORT_LOW:     cfg.short_low_time     <= pwdata[7:0];
        REG_ONE_RELEASE:   cfg.one_release_time   <= pwdata[7:0];
        REG_ZERO_LOW:      cfg.zero_low_time      <= pwdata[7:0];
        REG_READ_TAIL:     cfg.read_tail_time     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RESET_LOW:     prdata = {20'd0, cfg.reset_low_time};
      REG_PRESENCE_WAIT: prdata = {20'd0, cfg.presence_wait_time};
      REG_RESET_TAIL:    prdata = {20'd0, cfg.reset_tail_time};
      REG_SLOT_GAP:      prdata = {24'd0, cfg.slot_gap_time};
      REG_SHORT_LOW:     prdata = {24'd0, cfg.short_low_time};
      REG_ONE_RELEASE:   prdata = {24'd0, cfg.one_release_time};
      REG_ZERO_LOW:      prdata = {24'd0, cfg.zero_low_time};
      REG_READ_TAIL:     prdata = {24'd0, cfg.read_tail_time};
      default:           prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/owm_step.sv -----
// next-state logic for one microsecond tick of the bus master
`default_nettype none
module owm_step
  import owm_pkg::*;
(
  input  wire mst_state_t  st,
  input  wire cfg_t        cfg,
  input  wire logic [1:0]  op,
  input  wire logic [7:0]  tx_byte,
  input  wire logic        line_level,
  output mst_state_t       st_next,
  output tick_res_t        res
);

  // clamp a register value into the timer range, optional floor of one
  function automatic logic [TIME_BITS-1:0] tsat(input logic [11:0] v, input logic min1);
    logic [31:0] w;
    w = {20'd0, v};
    if (min1 && (w == 32'd0)) w = 32'd1;
    if (w > TMAX) w = TMAX;
    return w[TIME_BITS-1:0];
  endfunction

  function automatic mst_state_t go_end(input mst_state_t s);
    mst_state_t r;
    r = s;
    r.phase     = PH_IDLE;
    r.time_left = '0;
    return r;
  endfunction

  function automatic mst_state_t enter_slow(input mst_state_t s, input cfg_t c);
    mst_state_t r;
    r = s;
    r.phase = PH_SLOW;
    if (s.is_read || s.shift_data[0]) r.time_left = tsat({4'd0, c.short_low_time}, 1'b1);
    else                              r.time_left = tsat({4'd0, c.zero_low_time}, 1'b1);
    return r;
  endfunction

  function automatic mst_state_t enter_gap(input mst_state_t s, input cfg_t c);
    mst_state_t           r;
    logic [TIME_BITS-1:0] len;
    len = tsat({4'd0, c.slot_gap_time}, 1'b0);
    r = s;
    if (len != '0) begin
      r.phase     = PH_GAP;
      r.time_left = len;
    end else begin
      r = enter_slow(s, c);
    end
    return r;
  endfunction

  // end of a bit slot: shift out on a write, then next slot or finish
  function automatic mst_state_t slot_end(input mst_state_t s, input cfg_t c);
    mst_state_t r;
    r = s;
    if (!s.is_read) r.shift_data = {1'b0, s.shift_data[7:1]};
    if (s.bit_index == 3'd7) begin
      if (s.is_read) r.last_rx = r.shift_data;
      r = go_end(r);
    end else begin
      r.bit_index = s.bit_index + 3'd1;
      r = enter_gap(r, c);
    end
    return r;
  endfunction

  function automatic mst_state_t enter_rel(input mst_state_t s, input cfg_t c);
    mst_state_t           r;
    logic [TIME_BITS-1:0] len;
    len = tsat({4'd0, c.one_release_time}, 1'b0);
    r = s;
    if (len != '0) begin
      r.phase     = PH_REL;
      r.time_left = len;
    end else begin
      r = slot_end(s, c);
    end
    return r;
  endfunction

  function automatic mst_state_t enter_rdtail(input mst_state_t s, input cfg_t c);
    mst_state_t           r;
    logic [TIME_BITS-1:0] len;
    len = tsat({4'd0, c.read_tail_time}, 1'b0);
    r = s;
    if (len != '0) begin
      r.phase     = PH_RDTAIL;
      r.time_left = len;
    end else begin
      r = slot_end(s, c);
    end
    return r;
  endfunction

  function automatic mst_state_t enter_watch(input mst_state_t s);
    mst_state_t r;
    r = s;
    r.phase     = PH_RWATCH;
    r.time_left = {{(TIME_BITS-1){1'b0}}, 1'b1};
    return r;
  endfunction

  function automatic mst_state_t enter_rwait(input mst_state_t s, input cfg_t c);
    mst_state_t           r;
    logic [TIME_BITS-1:0] len;
    len = tsat(c.presence_wait_time, 1'b0);
    r = s;
    if (len != '0) begin
      r.phase     = PH_RWAIT;
      r.time_left = len;
    end else begin
      r = enter_watch(s);
    end
    return r;
  endfunction

  function automatic mst_state_t enter_rtail(input mst_state_t s, input cfg_t c);
    mst_state_t           r;
    logic [TIME_BITS-1:0] len;
    len = tsat(c.reset_tail_time, 1'b0);
    r = s;
    if (len != '0) begin
      r.phase     = PH_RTAIL;
      r.time_left = len;
    end else begin
      r = go_end(s);
    end
    return r;
  endfunction

  // move on when a timed phase runs out
  function automatic mst_state_t go_succ(input mst_state_t s, input cfg_t c);
    mst_state_t r;
    r = s;
    case (s.phase)
      PH_RLOW:  r = enter_rwait(s, c);
      PH_RWAIT: r = enter_watch(s);
      PH_GAP:   r = enter_slow(s, c);
      PH_SLOW: begin
        if (s.is_read) begin
          r.phase     = PH_SAMPLE;
          r.time_left = {{(TIME_BITS-1){1'b0}}, 1'b1};
        end else if (s.shift_data[0]) begin
          r = enter_rel(s, c);
        end else begin
          r = slot_end(s, c);
        end
      end
      PH_REL:    r = slot_end(s, c);
      PH_RDTAIL: r = slot_end(s, c);
      default:   r = go_end(s);
    endcase
    return r;
  endfunction

  mst_state_t sa;
  mst_state_t sb;

  // command start
  always_comb begin
    sa = st;
    if ((st.phase == PH_IDLE) && (op != OP_TICK)) begin
      sa.bit_index = 3'd0;
      if (op == OP_RESET) begin
        sa.is_read   = 1'b0;
        sa.phase     = PH_RLOW;
        sa.time_left = tsat(cfg.reset_low_time, 1'b1);
      end else begin
        sa.is_read    = (op == OP_READ);
        sa.shift_data = (op == OP_WRITE) ? tx_byte : 8'd0;
        sa = enter_gap(sa, cfg);
      end
    end
  end

  // tick of the active phase
  always_comb begin
    sb            = sa;
    res.busy      = 1'b0;
    res.drive_low = 1'b0;
    if (sa.phase != PH_IDLE) begin
      res.busy      = 1'b1;
      res.drive_low = (sa.phase == PH_RLOW) || (sa.phase == PH_SLOW);
      case (sa.phase)
        PH_RWATCH: begin
          if (!line_level) sb = enter_rtail(sa, cfg);
        end
        PH_SAMPLE: begin
          sb.shift_data = {line_level, sa.shift_data[7:1]};
          sb = enter_rdtail(sb, cfg);
        end
        default: begin
          if (sa.time_left != '0) sb.time_left = sa.time_left - TIME_BITS'(1);
          if (sb.time_left == '0) sb = go_succ(sb, cfg);
        end
      endcase
    end
    res.done = res.busy && (sb.phase == PH_IDLE);
  end

  assign st_next = sb;

endmodule
`default_nettype wire

// ----- sv/one_wire_bus_master_unit.sv -----
// top level of the one-wire bus master: handshake, state and result registers
`default_nettype none
// one-wire bus master, stepped by one input word per microsecond tick
//
// input channel (in_valid / in_stall): op, tx_byte and the sampled line_level;
//   op starts a reset, byte write or byte read when the master is idle and is
//   ignored while busy. every accepted word is one tick of bus time
// output channel (out_valid / out_stall): one result word per input word with
//   drive_low, busy_res, done_res and rx_byte describing that tick
// apb port: eight timing registers at byte address 4*index, zero wait states;
//   write them only while no command is running
//
// path: a word passes from the input register to the result register
// throughput: one word per cycle unless stalled; the tick update is a timer
//   decrement and a phase move done between the input and result registers
// stall: the result register holds while out_stall is high; the input register
//   still takes one more word and then in_stall rises until the result drains
// reset: synchronous; master goes idle, timers, shift register and last_rx clear,
//   timing registers return to their defaults, both pipeline registers empty
module one_wire_bus_master_unit
  import owm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // tick channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [7:0]        tx_byte,
  input  wire logic              line_level,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   drive_low,
  output logic                   busy_res,
  output logic                   done_res,
  output logic [7:0]             rx_byte,
  // apb
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  cfg_t       cfg;
  mst_state_t st;
  mst_state_t st_next;
  tick_res_t  res;

  // input register
  logic       in_full;
  logic [1:0] in_op;
  logic [7:0] in_tx;
  logic       in_line;

  logic accept;
  logic advance;

  // the tick moves into the result register when that is empty or draining
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign accept   = in_valid && !in_stall;

  owm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  owm_step u_step (
    .st         (st),
    .cfg        (cfg),
    .op         (in_op),
    .tx_byte    (in_tx),
    .line_level (in_line),
    .st_next    (st_next),
    .res        (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (accept) begin
      in_op   <= op;
      in_tx   <= tx_byte;
      in_line <= line_level;
    end
  end

  // master state, updated once per tick as it passes through
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.time_left  <= '0;
      st.bit_index  <= 3'd0;
      st.shift_data <= 8'd0;
      st.is_read    <= 1'b0;
      st.last_rx    <= 8'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      drive_low <= res.drive_low;
      busy_res  <= res.busy;
      done_res  <= res.done;
      rx_byte   <= st_next.last_rx;
    end
  end

endmodule
`default_nettype wire
